[rtl/core/chacha20_stream_cipher_unit_assert.svh]
`ifndef CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CC20_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CC20_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cc20_pkg.sv]
`default_nettype none

package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [3:0] widx_t;

  localparam int unsigned LANES = 4;
  localparam logic [3:0] MAX_BYTES = 4'd8;

  localparam word_t SIGMA_0 = 32'h61707865;
  localparam word_t SIGMA_1 = 32'h3320646e;
  localparam word_t SIGMA_2 = 32'h79622d32;
  localparam word_t SIGMA_3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY_01   = 3'd0;
  localparam logic [2:0] REG_KEY_23   = 3'd1;
  localparam logic [2:0] REG_KEY_45   = 3'd2;
  localparam logic [2:0] REG_KEY_67   = 3'd3;
  localparam logic [2:0] REG_NONCE_01 = 3'd4;
  localparam logic [2:0] REG_NONCE_2  = 3'd5;
  localparam logic [2:0] REG_COUNTER  = 3'd6;

  // Word indexes a, b, c, d of each quarter round: four columns, then four diagonals.
  localparam widx_t QR_LANES [8][4] = '{
    '{4'd0, 4'd4, 4'd8,  4'd12}, '{4'd1, 4'd5, 4'd9,  4'd13},
    '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
    '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
    '{4'd2, 4'd7, 4'd8,  4'd13}, '{4'd3, 4'd4, 4'd9,  4'd14}
  };

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce01;
    logic [31:0]      nonce2;
  } cc20_cfg_t;

  typedef struct packed {
    logic  start;
    word_t counter;
  } cc20_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cc20_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GEN,
    S_XOR
  } cc20_state_t;

  function automatic word_t rotl32(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t build_init(cc20_cfg_t cfg, word_t ctr);
    block_t s;
    s[0] = SIGMA_0;
    s[1] = SIGMA_1;
    s[2] = SIGMA_2;
    s[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2 * i] = cfg.key[i][31:0];
      s[5 + 2 * i] = cfg.key[i][63:32];
    end
    s[12] = ctr;
    s[13] = cfg.nonce01[31:0];
    s[14] = cfg.nonce01[63:32];
    s[15] = cfg.nonce2;
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cc20_qr_half.sv]
`default_nettype none

// One half of a quarter round: two add, xor, rotate steps.
module cc20_qr_half
  import cc20_pkg::*;
(
  input  wire word_t a_in,
  input  wire word_t b_in,
  input  wire word_t c_in,
  input  wire word_t d_in,
  input  wire logic  second,
  output word_t      a_out,
  output word_t      b_out,
  output word_t      c_out,
  output word_t      d_out
);

  word_t a1;
  word_t d1;
  word_t c1;
  word_t dx;
  word_t bx;

  always_comb begin
    a1 = a_in + b_in;
    dx = d_in ^ a1;
    d1 = second ? rotl32(dx, 8) : rotl32(dx, 16);
    c1 = c_in + d1;
    bx = b_in ^ c1;
    a_out = a1;
    d_out = d1;
    c_out = c1;
    b_out = second ? rotl32(bx, 7) : rotl32(bx, 12);
  end

endmodule

`default_nettype wire

[rtl/core/cc20_core.sv]
`default_nettype none

// Block function: four quarter-round lanes share the working state, one half
// round per cycle, and a final stage adds the input state to form the keystream.
module cc20_core
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cc20_cfg_t  cfg,
  input  wire cc20_ctrl_t ctrl,
  output cc20_stat_t      stat,
  output block_t          keystream
);

  localparam int unsigned STEPS  = DOUBLE_ROUNDS * 4;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  block_t            work;
  block_t            work_next;
  block_t            init;
  word_t             ctr;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              fin;

  word_t lane_in  [LANES][4];
  word_t lane_out [LANES][4];

  logic diag;
  logic second;

  assign second = step[0];
  assign diag   = step[1];
  assign init   = build_init(cfg, ctr);

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      for (int k = 0; k < 4; k++) begin
        lane_in[j][k] = diag ? work[QR_LANES[4 + j][k]] : work[QR_LANES[j][k]];
      end
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    cc20_qr_half u_qr (
      .a_in   (lane_in[j][0]),
      .b_in   (lane_in[j][1]),
      .c_in   (lane_in[j][2]),
      .d_in   (lane_in[j][3]),
      .second (second),
      .a_out  (lane_out[j][0]),
      .b_out  (lane_out[j][1]),
      .c_out  (lane_out[j][2]),
      .d_out  (lane_out[j][3])
    );
  end

  always_comb begin
    work_next = work;
    for (int j = 0; j < LANES; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (diag) begin
          work_next[QR_LANES[4 + j][k]] = lane_out[j][k];
        end else begin
          work_next[QR_LANES[j][k]] = lane_out[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      step <= '0;
    end else begin
      fin <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      ctr  <= ctrl.counter;
      work <= build_init(cfg, ctrl.counter);
    end else if (busy) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      for (int i = 0; i < 16; i++) begin
        keystream[i] <= init[i] + work[i];
      end
    end
  end

  assign stat = {busy, fin};

endmodule

`default_nettype wire

[rtl/core/chacha20_stream_cipher_unit.sv]
// Channel   Direction  Payload
// s_axis    in         tdata: data_in, byte_count; tlast: last_of_message
// m_axis    out        tdata: data_out, byte_count_out; tlast: last_out
// cfg       in         cfg_index selects the register, cfg_data is the value
//
// A word that opens a keystream block waits on the half-round steps of the block
// function from accept to the next accept; any other word goes from accept straight
// to the XOR state. One request is in work at a time.
// A result waits in the output register while the next request is accepted.
// Reset is synchronous; a last word returns the block position and number to zero.
`default_nettype none

module chacha20_stream_cipher_unit
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // data_in [63:0], byte_count [67:64]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // data_out [63:0], byte_count_out [67:64]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cc20_cfg_t   cfg;
  word_t       cfg_counter;
  cc20_ctrl_t  ctrl;
  cc20_stat_t  stat;
  block_t      keystream;
  logic        core_start;

  cc20_state_t state;
  cc20_state_t state_next;

  logic [2:0]  word_pos;
  word_t       block_num;
  logic [63:0] item_data;
  logic [3:0]  item_cnt;
  logic        item_last;

  logic        out_valid;
  logic [63:0] out_data;
  logic [3:0]  out_cnt;
  logic        out_last;

  logic        accept;
  logic        load_out;
  logic [3:0]  in_cnt;
  logic [63:0] ks_pair;
  logic [63:0] xored;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg         <= '0;
      cfg_counter <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_01:   cfg.key[0]  <= cfg_data;
        REG_KEY_23:   cfg.key[1]  <= cfg_data;
        REG_KEY_45:   cfg.key[2]  <= cfg_data;
        REG_KEY_67:   cfg.key[3]  <= cfg_data;
        REG_NONCE_01: cfg.nonce01 <= cfg_data;
        REG_NONCE_2:  cfg.nonce2  <= cfg_data[31:0];
        REG_COUNTER:  cfg_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .stat      (stat),
    .keystream (keystream)
  );

  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_cnt = (s_axis_tdata[67:64] > MAX_BYTES) ? MAX_BYTES : s_axis_tdata[67:64];
  assign ctrl   = {core_start, cfg_counter + block_num};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    core_start    = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (word_pos == '0) begin
            core_start = 1'b1;
            state_next = S_GEN;
          end else begin
            state_next = S_XOR;
          end
        end
      end
      S_GEN: begin
        if (stat.done) begin
          state_next = S_XOR;
        end
      end
      S_XOR: begin
        if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_data <= s_axis_tdata[63:0];
      item_cnt  <= in_cnt;
      item_last <= s_axis_tlast;
    end
  end

  assign ks_pair = {keystream[{word_pos, 1'b1}], keystream[{word_pos, 1'b0}]};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      xored[8 * k +: 8] = (item_cnt > 4'(k)) ? (item_data[8 * k +: 8] ^ ks_pair[8 * k +: 8])
                                             : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_pos  <= '0;
      block_num <= '0;
    end else if (load_out) begin
      if (item_last) begin
        word_pos  <= '0;
        block_num <= '0;
      end else begin
        word_pos <= word_pos + 1'b1;
        if (word_pos == 3'd7) begin
          block_num <= block_num + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= xored;
      out_cnt  <= item_cnt;
      out_last <= item_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_cnt, out_data};
  assign m_axis_tlast  = out_last;

`include "chacha20_stream_cipher_unit_assert.svh"

  `CC20_ASSERT_NOW(a_busy_in_gen, clk, rst, stat.busy, state == S_GEN, "core busy outside block generation")
  `CC20_ASSERT_NEXT(a_mid_block_skips_gen, clk, rst, accept && word_pos != 3'd0, state == S_XOR, "mid-block word started the block function")
  `CC20_ASSERT_NEXT(a_last_rewinds, clk, rst, load_out && item_last, word_pos == 3'd0 && block_num == '0, "last word did not rewind position")
  `CC20_ASSERT_NOW(a_load_ready, clk, rst, load_out && out_valid, m_axis_tready, "output overwritten while waiting")

endmodule

`default_nettype wire
